FILE: hdl/nsms_pkg.sv
// Shared types and codes for the navigation mode supervisor.
// Used by nav_sensor_mode_supervisor; depends on nothing else.
package nsms_pkg;

    localparam int NUM_SENSORS = 5;

    // Navigation modes
    localparam logic [2:0] MODE_NOM = 3'd0;
    localparam logic [2:0] MODE_DR  = 3'd1;
    localparam logic [2:0] MODE_LA  = 3'd2;
    localparam logic [2:0] MODE_REL = 3'd3;
    localparam logic [2:0] MODE_FS  = 3'd4;

    // Sensor indexes
    localparam int SNS_IMU   = 0;
    localparam int SNS_GPS   = 1;
    localparam int SNS_LIDAR = 2;
    localparam int SNS_LOOP  = 4;
    localparam logic [2:0] SNS_LAST = 3'd4;

    localparam logic [NUM_SENSORS-1:0] HEALTH_DEFAULT = 5'b00011;

    // Operation codes
    localparam logic [1:0] OP_STATUS   = 2'd0;
    localparam logic [1:0] OP_EVALUATE = 2'd1;
    localparam logic [1:0] OP_FORCE    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_INITIAL_MODE = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_MS   = 2'd1;
    localparam logic [1:0] CFG_HOLD_MS      = 2'd2;

    // Reason codes
    localparam logic [3:0] RSN_NONE          = 4'd0;
    localparam logic [3:0] RSN_IMU_FAIL_NOM  = 4'd1;
    localparam logic [3:0] RSN_GPS_LOST      = 4'd2;
    localparam logic [3:0] RSN_TIMEOUT       = 4'd3;
    localparam logic [3:0] RSN_GPS_BACK      = 4'd4;
    localparam logic [3:0] RSN_LIDAR_OK      = 4'd5;
    localparam logic [3:0] RSN_IMU_FAIL_DR   = 4'd6;
    localparam logic [3:0] RSN_LOOP_CLOSURE  = 4'd7;
    localparam logic [3:0] RSN_LIDAR_LOST    = 4'd8;
    localparam logic [3:0] RSN_IMU_FAIL      = 4'd9;
    localparam logic [3:0] RSN_GPS_BACK_REL  = 4'd10;
    localparam logic [3:0] RSN_RECOVERED     = 4'd11;
    localparam logic [3:0] RSN_FORCED        = 4'd12;

    localparam logic [31:0] TIMEOUT_RESET = 32'd60000;
    localparam logic [31:0] HOLD_RESET    = 32'd2000;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  sensor_id;
        logic        healthy;
        logic [31:0] now_ms;
        logic [2:0]  target_mode;
    } in_item_t;

    typedef struct packed {
        logic [2:0] current_mode;
        logic [2:0] prev_mode;
        logic       changed;
        logic [3:0] reason_code;
    } out_item_t;

endpackage

FILE: hdl/nav_sensor_mode_supervisor.sv
// Navigation mode supervisor: sensor health tracking and mode rules.
// Depends on nsms_pkg for codes and item types.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  s_      | in        | s_tvalid / s_tready    | s_tuser op, s_tdata item fields
//  m_      | out       | m_tvalid / m_tready    | m_tdata result fields
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Sustains one transaction per cycle unless m_ stalls: an input register, then
// the mode rules (three parallel 32-bit subtract-and-compare paths and a priority mux)
// feeding the result register. The state updates when the item leaves the input register.
// aresetn is synchronous, active low. A stall on m_ backs up through the result and
// input registers to s_tready; cfg_ready is always high.
module nav_sensor_mode_supervisor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] sensor_id, [3] healthy, [35:4] now_ms,
                                   // [38:36] target_mode, [39] zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] current_mode, [5:3] prev_mode, [6] changed,
                                   // [10:7] reason_code, [15:11] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int NS = nsms_pkg::NUM_SENSORS;

    // Configuration registers
    logic [2:0]  boot_mode_reg;
    logic [31:0] timeout_ms_reg;
    logic [31:0] hold_ms_reg;

    // Supervisor state
    logic [2:0]    mode_reg, mode_next;
    logic [31:0]   entry_time_reg, entry_time_next;
    logic [NS-1:0] health_reg, health_next;
    logic [NS-1:0] tracked_reg, tracked_next;
    logic [31:0]   stamp_reg [NS];
    logic [NS-1:0] stamp_wr;

    // Pipeline registers
    logic                 in_valid_reg;
    nsms_pkg::in_item_t   in_item_reg;
    logic                 out_valid_reg;
    nsms_pkg::out_item_t  out_item_reg, out_item_next;

    logic out_free;
    logic advance;
    logic cfg_write;
    logic restart;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;
    assign restart   = cfg_write && (cfg_index == nsms_pkg::CFG_INITIAL_MODE)
                       && (cfg_data[2:0] <= nsms_pkg::MODE_FS);

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_item_reg.reason_code, out_item_reg.changed,
                       out_item_reg.prev_mode, out_item_reg.current_mode};

    // Mode rules for the item in the input register
    always_comb begin
        logic [NS-1:0] trk_eval;
        logic [31:0]   now;
        logic [31:0]   gps_stamp;
        logic [31:0]   lidar_stamp;
        logic          gps_rec;
        logic          lidar_rec;
        logic          dr_expired;
        logic [2:0]    nm;
        logic [3:0]    why;
        logic          chg;

        now         = in_item_reg.now_ms;
        trk_eval    = tracked_reg | health_reg;
        gps_stamp   = tracked_reg[nsms_pkg::SNS_GPS] ? stamp_reg[nsms_pkg::SNS_GPS] : now;
        lidar_stamp = tracked_reg[nsms_pkg::SNS_LIDAR] ? stamp_reg[nsms_pkg::SNS_LIDAR] : now;
        gps_rec     = health_reg[nsms_pkg::SNS_GPS] && ((now - gps_stamp) >= hold_ms_reg);
        lidar_rec   = health_reg[nsms_pkg::SNS_LIDAR] && ((now - lidar_stamp) >= hold_ms_reg);
        dr_expired  = (now - entry_time_reg) > timeout_ms_reg;

        nm  = mode_reg;
        why = nsms_pkg::RSN_NONE;
        chg = 1'b0;

        mode_next       = mode_reg;
        entry_time_next = entry_time_reg;
        health_next     = health_reg;
        tracked_next    = tracked_reg;
        stamp_wr        = '0;

        unique case (in_item_reg.op)
            nsms_pkg::OP_STATUS: begin
                if (in_item_reg.sensor_id <= nsms_pkg::SNS_LAST) begin
                    if (!health_reg[in_item_reg.sensor_id] && in_item_reg.healthy) begin
                        tracked_next[in_item_reg.sensor_id] = 1'b0;
                    end
                    health_next[in_item_reg.sensor_id] = in_item_reg.healthy;
                end
            end
            nsms_pkg::OP_EVALUATE: begin
                // Stamp healthy sensors that are not yet tracked
                stamp_wr     = health_reg & ~tracked_reg;
                tracked_next = trk_eval;
                unique case (mode_reg)
                    nsms_pkg::MODE_NOM: begin
                        if (!health_reg[nsms_pkg::SNS_IMU]) begin
                            nm = nsms_pkg::MODE_FS; why = nsms_pkg::RSN_IMU_FAIL_NOM;
                        end else if (!health_reg[nsms_pkg::SNS_GPS]) begin
                            nm = nsms_pkg::MODE_DR; why = nsms_pkg::RSN_GPS_LOST;
                        end
                    end
                    nsms_pkg::MODE_DR: begin
                        if (dr_expired) begin
                            nm = nsms_pkg::MODE_FS; why = nsms_pkg::RSN_TIMEOUT;
                        end else if (gps_rec) begin
                            nm = nsms_pkg::MODE_NOM; why = nsms_pkg::RSN_GPS_BACK;
                        end else if (lidar_rec) begin
                            nm = nsms_pkg::MODE_LA; why = nsms_pkg::RSN_LIDAR_OK;
                        end else if (!health_reg[nsms_pkg::SNS_IMU]) begin
                            nm = nsms_pkg::MODE_FS; why = nsms_pkg::RSN_IMU_FAIL_DR;
                        end
                    end
                    nsms_pkg::MODE_LA: begin
                        if (gps_rec) begin
                            nm = nsms_pkg::MODE_NOM; why = nsms_pkg::RSN_GPS_BACK;
                        end else if (health_reg[nsms_pkg::SNS_LOOP]) begin
                            nm = nsms_pkg::MODE_REL; why = nsms_pkg::RSN_LOOP_CLOSURE;
                        end else if (!health_reg[nsms_pkg::SNS_LIDAR]) begin
                            nm = nsms_pkg::MODE_DR; why = nsms_pkg::RSN_LIDAR_LOST;
                        end else if (!health_reg[nsms_pkg::SNS_IMU]) begin
                            nm = nsms_pkg::MODE_FS; why = nsms_pkg::RSN_IMU_FAIL;
                        end
                    end
                    nsms_pkg::MODE_REL: begin
                        if (gps_rec) begin
                            nm = nsms_pkg::MODE_NOM; why = nsms_pkg::RSN_GPS_BACK_REL;
                        end else if (!health_reg[nsms_pkg::SNS_IMU]) begin
                            nm = nsms_pkg::MODE_FS; why = nsms_pkg::RSN_IMU_FAIL;
                        end
                    end
                    nsms_pkg::MODE_FS: begin
                        if (health_reg[nsms_pkg::SNS_IMU] && (gps_rec || lidar_rec)) begin
                            nm = nsms_pkg::MODE_NOM; why = nsms_pkg::RSN_RECOVERED;
                        end
                    end
                    default: begin
                        nm = mode_reg;
                    end
                endcase
                if (nm != mode_reg) begin
                    chg             = 1'b1;
                    mode_next       = nm;
                    entry_time_next = now;
                    tracked_next    = '0;
                end
            end
            nsms_pkg::OP_FORCE: begin
                if ((in_item_reg.target_mode <= nsms_pkg::MODE_FS)
                    && (in_item_reg.target_mode != mode_reg)) begin
                    chg             = 1'b1;
                    why             = nsms_pkg::RSN_FORCED;
                    mode_next       = in_item_reg.target_mode;
                    entry_time_next = '0;
                    tracked_next    = '0;
                end
            end
            default: begin
                chg = 1'b0;
            end
        endcase

        out_item_next.current_mode = mode_next;
        out_item_next.prev_mode    = mode_reg;
        out_item_next.changed      = chg;
        out_item_next.reason_code  = chg ? why : nsms_pkg::RSN_NONE;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boot_mode_reg  <= nsms_pkg::MODE_NOM;
            timeout_ms_reg <= nsms_pkg::TIMEOUT_RESET;
            hold_ms_reg    <= nsms_pkg::HOLD_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                nsms_pkg::CFG_INITIAL_MODE: begin
                    if (restart) begin
                        boot_mode_reg <= cfg_data[2:0];
                    end
                end
                nsms_pkg::CFG_TIMEOUT_MS: timeout_ms_reg <= cfg_data;
                nsms_pkg::CFG_HOLD_MS:    hold_ms_reg    <= cfg_data;
                default: begin
                    hold_ms_reg <= hold_ms_reg;
                end
            endcase
        end
    end

    // Supervisor state: restart on reset or a valid boot mode write, else update per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= nsms_pkg::MODE_NOM;
            entry_time_reg <= '0;
            health_reg     <= nsms_pkg::HEALTH_DEFAULT;
            tracked_reg    <= '0;
        end else if (restart) begin
            mode_reg       <= cfg_data[2:0];
            entry_time_reg <= '0;
            health_reg     <= nsms_pkg::HEALTH_DEFAULT;
            tracked_reg    <= '0;
        end else if (advance) begin
            mode_reg       <= mode_next;
            entry_time_reg <= entry_time_next;
            health_reg     <= health_next;
            tracked_reg    <= tracked_next;
        end
    end

    // Recovery stamps: written only on evaluate, read only while tracked
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NS; i++) begin
            if (advance && stamp_wr[i]) begin
                stamp_reg[i] <= in_item_reg.now_ms;
            end
        end
    end

    // Input register: load on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.op          <= s_tuser;
            in_item_reg.sensor_id   <= s_tdata[2:0];
            in_item_reg.healthy     <= s_tdata[3];
            in_item_reg.now_ms      <= s_tdata[35:4];
            in_item_reg.target_mode <= s_tdata[38:36];
        end
    end

    // Result register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

endmodule
